### rtl/ohr_pkg.sv
`default_nettype none

package ohr_pkg;

  // Ring geometry.
  localparam int DEPTH       = 16;
  localparam int RECORD_BITS = 32;
  localparam int IDX_W       = $clog2(DEPTH);

  // Field widths fixed by the interface.
  localparam int KIND_W = 3;
  localparam int AGE_W  = 4;
  localparam int CNT_W  = 5;
  localparam int OUT_W  = 32;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ_AGE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ_NEXT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RST_CUR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  // Configuration register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [RECORD_BITS-1:0] record_data;
    logic [AGE_W-1:0]       age;
  } ohr_in_t;

  typedef struct packed {
    logic             ok;
    logic [OUT_W-1:0] record_out;
    logic [CNT_W-1:0] count;
  } ohr_out_t;

endpackage

`default_nettype wire

### rtl/overwrite_ring_history_unit.sv
// A result appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; busy never rises, and the index update
// plus one store access fit between the accept edge and the result register.
// Reset (rst, synchronous): the ring is empty and the capacity register is DEPTH.
// Results are shown for one cycle with result_valid; the receiver cannot stall.
`default_nettype none

module overwrite_ring_history_unit
  import ohr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Command channel.
  input  wire logic        start,
  output logic             busy,
  input  wire ohr_in_t     request,
  // Result channel.
  output logic             result_valid,
  output ohr_out_t         result,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Capacity register, raw as written. Values above DEPTH act as DEPTH.
  logic [CNT_W-1:0] capacity;

  // Ring indices. The slot indices stay below a nonzero effective capacity and the
  // count never exceeds it, because a capacity write always empties the ring.
  logic [IDX_W-1:0] newest_next_slot, newest_next_slot_next;
  logic [IDX_W-1:0] oldest_slot, oldest_slot_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [IDX_W-1:0] cursor, cursor_next;
  logic             walk_done, walk_done_next;

  // Result stage.
  logic             res_ok;
  logic [CNT_W-1:0] res_count;
  logic             res_has_rec;

  logic                   accept;
  logic                   cfg_write;
  logic [CNT_W-1:0]       cap_eff;
  logic                   cap_on;
  logic [IDX_W-1:0]       cap_last;
  logic [IDX_W-1:0]       newest_slot;
  logic signed [CNT_W:0]  age_diff;
  logic [IDX_W-1:0]       age_slot;
  logic                   age_hit;
  logic                   next_hit;
  logic                   ok_next;
  logic                   rd_en;
  logic                   wr_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [RECORD_BITS-1:0] rd_data;

  function automatic logic [IDX_W-1:0] age_ext(input logic [AGE_W-1:0] a);
    return IDX_W'(a);
  endfunction

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CNT_W){1'b0}}, capacity} : 32'd0;

  assign cap_eff  = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
  assign cap_on   = (cap_eff != '0);
  assign cap_last = IDX_W'(cap_eff - CNT_W'(1));

  // Slot of the newest record: one step back from the append slot, wrapping.
  assign newest_slot = (newest_next_slot == '0) ? cap_last
                                                : newest_next_slot - IDX_W'(1);

  // Slot of a record of a given age. For an age below the held count the difference
  // is never below minus the capacity, so a single conditional add wraps it into range.
  assign age_diff = $signed({2'b00, newest_next_slot}) - $signed((CNT_W+1)'(1))
                  - $signed({2'b00, age_ext(request.age)});
  assign age_slot = (age_diff < 0) ? IDX_W'(age_diff + $signed({1'b0, cap_eff}))
                                   : IDX_W'(age_diff);

  assign age_hit  = (CNT_W'(request.age) < held_count);
  assign next_hit = (held_count != '0) && !walk_done;

  assign rd_addr = (request.kind == KIND_READ_AGE) ? age_slot : cursor;
  assign wr_en   = accept && cap_on && (request.kind == KIND_APPEND);

  // Operation decode. Besides a capacity write, state only moves on an accepted
  // transaction with a nonzero capacity; unknown operation codes leave the state untouched.
  always_comb begin
    newest_next_slot_next = newest_next_slot;
    oldest_slot_next      = oldest_slot;
    held_count_next       = held_count;
    cursor_next           = cursor;
    walk_done_next        = walk_done;
    ok_next               = 1'b0;
    rd_en                 = 1'b0;
    if (cap_on) begin
      case (request.kind)
        KIND_APPEND: begin
          newest_next_slot_next = (newest_next_slot == cap_last) ? '0
                                : newest_next_slot + IDX_W'(1);
          if (held_count >= cap_eff) begin
            // Full ring: the oldest record is overwritten.
            oldest_slot_next = (oldest_slot == cap_last) ? '0 : oldest_slot + IDX_W'(1);
          end else begin
            held_count_next = held_count + CNT_W'(1);
          end
          // The record just written becomes the newest one.
          cursor_next    = newest_next_slot;
          walk_done_next = 1'b0;
          ok_next        = 1'b1;
        end
        KIND_READ_AGE: begin
          ok_next = age_hit;
          rd_en   = age_hit;
        end
        KIND_READ_NEXT: begin
          if (next_hit) begin
            ok_next = 1'b1;
            rd_en   = 1'b1;
            if (cursor == oldest_slot) begin
              walk_done_next = 1'b1;
            end else begin
              cursor_next = (cursor == '0) ? cap_last : cursor - IDX_W'(1);
            end
          end
        end
        KIND_RST_CUR: begin
          if (held_count != '0) begin
            cursor_next    = newest_slot;
            walk_done_next = 1'b0;
          end
          ok_next = 1'b1;
        end
        KIND_CLEAR: begin
          newest_next_slot_next = '0;
          oldest_slot_next      = '0;
          held_count_next       = '0;
          cursor_next           = '0;
          walk_done_next        = 1'b0;
          ok_next               = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity         <= CNT_W'(DEPTH);
      newest_next_slot <= '0;
      oldest_slot      <= '0;
      held_count       <= '0;
      cursor           <= '0;
      walk_done        <= 1'b0;
      result_valid     <= 1'b0;
      res_ok           <= 1'b0;
      res_count        <= '0;
      res_has_rec      <= 1'b0;
    end else begin
      result_valid <= accept;
      if (accept) begin
        res_ok      <= ok_next;
        res_count   <= held_count_next;
        res_has_rec <= rd_en;
      end
      // A capacity write empties the ring but keeps the stored records.
      if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
        capacity         <= pwdata[CNT_W-1:0];
        newest_next_slot <= '0;
        oldest_slot      <= '0;
        held_count       <= '0;
        cursor           <= '0;
        walk_done        <= 1'b0;
      end else if (accept) begin
        newest_next_slot <= newest_next_slot_next;
        oldest_slot      <= oldest_slot_next;
        held_count       <= held_count_next;
        cursor           <= cursor_next;
        walk_done        <= walk_done_next;
      end
    end
  end

  ohr_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (newest_next_slot),
    .wdata (request.record_data),
    .re    (accept && rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Records only appear on a successful read; every other result shows zero.
  always_comb begin
    result.ok         = res_ok;
    result.count      = res_count;
    result.record_out = res_has_rec ? OUT_W'(rd_data) : '0;
  end

endmodule

`default_nettype wire

### rtl/ohr_store.sv
`default_nettype none

module ohr_store
  import ohr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [IDX_W-1:0]       waddr,
  input  wire logic [RECORD_BITS-1:0] wdata,
  input  wire logic                   re,
  input  wire logic [IDX_W-1:0]       raddr,
  output logic      [RECORD_BITS-1:0] rdata
);

  logic [RECORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the result stage uses this as its data register.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/ohr_checker.sv
`default_nettype none

module ohr_checker
  import ohr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire ohr_in_t  request,
  input wire logic     result_valid,
  input wire ohr_out_t result
);

  // Every accepted transaction produces exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> result_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !result_valid)
    else $error("result without an accepted transaction");

  // The ring never reports more records than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.count <= CNT_W'(DEPTH)))
    else $error("count above ring depth");

  // A successful clear always leaves the ring empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.ok && ($past(request.kind) == KIND_CLEAR))
      |-> (result.count == '0))
    else $error("clear left records in the ring");

  // A failed operation never returns a record.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ok) |-> (result.record_out == '0))
    else $error("failed operation returned data");

endmodule

bind overwrite_ring_history_unit ohr_checker u_ohr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .request      (request),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire
